### rtl/dmwb_pkg.sv
// Shared constants for the direct-mapped write-back cache.
// Used by every module of the block; no dependencies.
package dmwb_pkg;

  localparam int NUM_LINES_DEF = 4;
  localparam int MEM_WAIT_DEF  = 2;
  localparam int ADDR_BITS_DEF = 16;

  localparam int ADDR_PORT_W   = 16;
  localparam int WORD_W        = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int RECIP_SHIFT   = 31;

  localparam logic [WORD_W-1:0] FILL_OFFSET = 32'd100;

endpackage

### rtl/dmwb_front.sv
// Request front end: takes requests, masks the address and splits off the line index.
// Uses a reciprocal multiply plus one correction step. Depends on dmwb_pkg.
module dmwb_front import dmwb_pkg::*; #(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_cmd,
  input  logic [ADDR_PORT_W-1:0]   in_address,
  input  logic signed [WORD_W-1:0] in_write_data,
  input  logic                     hold,
  output logic                     q_push,
  input  logic                     q_full,
  output logic [((ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W)
                + ((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1) + WORD_W:0] q_wdata
);

  localparam int AW = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
  localparam int IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / NUM_LINES);

  logic                a_vld_r, a_vld_nxt;
  logic                a_cmd_r;
  logic [AW-1:0]       a_addr_r;
  logic [AW-1:0]       a_q_r;
  logic [WORD_W-1:0]   a_wdata_r;
  logic                a_load;
  logic [AW-1:0]       addr_m;
  logic [AW+31:0]      prod;
  logic [31:0]         qn;
  logic [31:0]         r0;
  logic [31:0]         rem;

  assign addr_m = in_address[AW-1:0];
  assign prod   = (AW+32)'(addr_m) * (AW+32)'(RECIP);

  assign full   = hold || (a_vld_r && q_full);
  assign a_load = push && !full;
  assign q_push = a_vld_r && !q_full;

  // quotient estimate is low by at most one; fold the remainder back once
  assign qn  = 32'(a_q_r) * 32'(NUM_LINES);
  assign r0  = 32'(a_addr_r) - qn;
  assign rem = (r0 >= 32'(NUM_LINES)) ? (r0 - 32'(NUM_LINES)) : r0;

  assign q_wdata = {a_cmd_r, a_addr_r, rem[IW-1:0], a_wdata_r};

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (a_load) begin
      a_vld_nxt = 1'b1;
    end else if (q_push) begin
      a_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_cmd_r   <= in_cmd;
      a_addr_r  <= addr_m;
      a_q_r     <= prod[RECIP_SHIFT +: AW];
      a_wdata_r <= in_write_data;
    end
  end

endmodule

### rtl/dmwb_queue.sv
// Short request queue between the front end and the line engine.
// Plain register FIFO; depends on dmwb_pkg for the default depth.
module dmwb_queue import dmwb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/dmwb_back.sv
// Line engine: line store, tag compare, write-back flag, fill and result register.
// Clears the line store after reset. Depends on dmwb_pkg.
module dmwb_back import dmwb_pkg::*; #(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int MEM_WAIT  = MEM_WAIT_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  logic [((ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W)
                + ((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1) + WORD_W:0] q_rdata,
  output logic                     q_pop,
  output logic                     hold,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [WORD_W-1:0] out_read_data,
  output logic                     out_was_hit,
  output logic                     out_wrote_back
);

  localparam int AW = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
  localparam int IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int QW = AW + IW + WORD_W + 1;
  localparam int WW = (MEM_WAIT > 0) ? $clog2(MEM_WAIT + 1) : 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] word;
  } line_t;

  line_t             mem [NUM_LINES];
  line_t             rd_r;
  line_t             new_line;
  line_t             mem_wd;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_wa;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [WW-1:0]     wait_r, wait_nxt;

  logic              req_cmd_r;
  logic [AW-1:0]     req_addr_r;
  logic [IW-1:0]     req_idx_r;
  logic [WORD_W-1:0] req_wdata_r;

  logic              res_valid_r, res_valid_nxt;
  logic [WORD_W-1:0] res_data_r, res_data_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_wb_r, res_wb_nxt;

  logic              q_cmd;
  logic [AW-1:0]     q_addr;
  logic [IW-1:0]     q_idx;
  logic [WORD_W-1:0] q_wdata;
  logic              hit;
  logic              wb;

  assign q_cmd   = q_rdata[QW-1];
  assign q_addr  = q_rdata[QW-2 -: AW];
  assign q_idx   = q_rdata[WORD_W +: IW];
  assign q_wdata = q_rdata[WORD_W-1:0];

  assign hit = rd_r.valid && (rd_r.addr == req_addr_r);
  assign wb  = !hit && rd_r.valid && rd_r.dirty;

  always_comb begin
    new_line.valid = 1'b1;
    new_line.addr  = req_addr_r;
    if (hit) begin
      new_line.dirty = rd_r.dirty || req_cmd_r;
      new_line.word  = req_cmd_r ? req_wdata_r : rd_r.word;
    end else begin
      new_line.dirty = req_cmd_r;
      new_line.word  = req_cmd_r ? req_wdata_r : (WORD_W'(req_addr_r) + FILL_OFFSET);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    wait_nxt      = wait_r;
    res_valid_nxt = res_valid_r && !pop;
    res_data_nxt  = res_data_r;
    res_hit_nxt   = res_hit_r;
    res_wb_nxt    = res_wb_r;
    mem_we        = 1'b0;
    mem_wa        = req_idx_r;
    mem_wd        = new_line;
    mem_re        = 1'b0;
    q_pop         = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == IW'(NUM_LINES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty && (!res_valid_r || pop)) begin
          q_pop     = 1'b1;
          mem_re    = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        mem_we       = 1'b1;
        res_data_nxt = new_line.word;
        res_hit_nxt  = hit;
        res_wb_nxt   = wb;
        if (!hit && (MEM_WAIT > 0)) begin
          wait_nxt  = WW'(MEM_WAIT - 1);
          state_nxt = S_WAIT;
        end else begin
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WAIT: begin
        if (wait_r == '0) begin
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          wait_nxt = wait_r - WW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wait_r     <= wait_nxt;
    res_data_r <= res_data_nxt;
    res_hit_r  <= res_hit_nxt;
    res_wb_r   <= res_wb_nxt;
    if (q_pop) begin
      req_cmd_r   <= q_cmd;
      req_addr_r  <= q_addr;
      req_idx_r   <= q_idx;
      req_wdata_r <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_r <= mem[q_idx];
    end
  end

  assign hold           = (state_r == S_CLEAR);
  assign empty          = !res_valid_r;
  assign out_read_data  = res_data_r;
  assign out_was_hit    = res_hit_r;
  assign out_wrote_back = res_wb_r;

`ifndef SYNTHESIS
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !(res_hit_r && res_wb_r))
    else $error("write-back flagged on a hit");

  a_look_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> ($past(state_r) == S_IDLE))
    else $error("lookup entered without a dequeue");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LOOK) || (state_r == S_WAIT)) |-> !res_valid_r)
    else $error("result register busy while a request is in flight");
`endif

endmodule

### rtl/direct_mapped_writeback_cache_unit.sv
// Direct-mapped write-back, write-allocate cache with one-word lines. A request
// first passes a one-stage front end that splits off the line index, then waits in
// a two-entry queue for the line engine. The line engine reads the line store
// (one registered read) and writes it back the next cycle; a miss then also waits
// in the memory wait state when MEM_WAIT is above zero. This read-then-update of
// the single-port line store sets the sustained rate. On a hit the result passes
// the front register, a queue slot, the line read register and the result register
// on its way to the out_ ports. A result waits in an output register until popped.
// After reset the line store is cleared one line per cycle, while full stays high.
// Top level; depends on dmwb_pkg, dmwb_front, dmwb_queue and dmwb_back.
module direct_mapped_writeback_cache_unit import dmwb_pkg::*; #(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int MEM_WAIT  = MEM_WAIT_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_cmd,
  input  logic [ADDR_PORT_W-1:0]   in_address,
  input  logic signed [WORD_W-1:0] in_write_data,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [WORD_W-1:0] out_read_data,
  output logic                     out_was_hit,
  output logic                     out_wrote_back
);

  localparam int AW = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
  localparam int IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int QW = AW + IW + WORD_W + 1;

  logic          hold;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  dmwb_front #(
    .NUM_LINES (NUM_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .hold          (hold),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_wdata       (q_wdata)
  );

  dmwb_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dmwb_back #(
    .NUM_LINES (NUM_LINES),
    .MEM_WAIT  (MEM_WAIT),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .hold           (hold),
    .empty          (empty),
    .pop            (pop),
    .out_read_data  (out_read_data),
    .out_was_hit    (out_was_hit),
    .out_wrote_back (out_wrote_back)
  );

endmodule

### sim/dmwb_checker.sv
`timescale 1ns / 1ps
// Request codes shared by the cache testbench, and the checker that mirrors the
// line state, predicts each result word and compares it. Depends on dmwb_pkg.
package dmwb_tb_pkg;
  typedef enum logic {CMD_READ = 1'b0, CMD_WRITE = 1'b1} cache_cmd_e;
endpackage

module dmwb_checker import dmwb_pkg::*; import dmwb_tb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     full,
  input  logic                     in_cmd,
  input  logic [ADDR_PORT_W-1:0]   in_address,
  input  logic signed [WORD_W-1:0] in_write_data,
  input  logic                     empty,
  input  logic                     pop,
  input  logic signed [WORD_W-1:0] out_read_data,
  input  logic                     out_was_hit,
  input  logic                     out_wrote_back,
  output int                       fail_count,
  output int                       pending
);

  localparam int IXW = (NUM_LINES_DEF > 1) ? $clog2(NUM_LINES_DEF) : 1;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              was_hit;
    logic              wrote_back;
  } access_result_t;

  logic                     line_valid [NUM_LINES_DEF];
  logic                     line_dirty [NUM_LINES_DEF];
  logic [ADDR_BITS_DEF-1:0] line_tag   [NUM_LINES_DEF];
  logic [WORD_W-1:0]        line_word  [NUM_LINES_DEF];
  access_result_t           expected_words [$];
  int                       fails = 0;

  function automatic access_result_t cache_access(cache_cmd_e cmd,
                                                  logic [ADDR_PORT_W-1:0] address,
                                                  logic [WORD_W-1:0] wdata);
    logic [ADDR_BITS_DEF-1:0] a;
    logic [ADDR_BITS_DEF-1:0] tg;
    logic [IXW-1:0]           ix;
    access_result_t           r;
    a  = ADDR_BITS_DEF'(address);
    ix = IXW'(a % NUM_LINES_DEF);
    tg = ADDR_BITS_DEF'(a / NUM_LINES_DEF);
    r.was_hit    = line_valid[ix] && (line_tag[ix] == tg);
    r.wrote_back = 1'b0;
    if (!r.was_hit) begin
      r.wrote_back   = line_valid[ix] && line_dirty[ix];
      line_tag[ix]   = tg;
      line_word[ix]  = WORD_W'(a) + FILL_OFFSET;
      line_valid[ix] = 1'b1;
      line_dirty[ix] = 1'b0;
    end
    if (cmd == CMD_WRITE) begin
      line_word[ix]  = wdata;
      line_dirty[ix] = 1'b1;
    end
    r.read_data = line_word[ix];
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES_DEF; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_word[i]  = '0;
      end
      expected_words.delete();
    end else begin
      if (push && !full)
        expected_words.push_back(cache_access(cache_cmd_e'(in_cmd), in_address,
                                              in_write_data));
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected word read_data=%0d was_hit=%0b wrote_back=%0b",
                   $realtime, out_read_data, out_was_hit, out_wrote_back);
        end else begin
          want = expected_words.pop_front();
          if (out_read_data !== want.read_data) begin
            fails++;
            $display("%0t: read_data expected %0d got %0d", $realtime,
                     $signed(want.read_data), out_read_data);
          end
          if (out_was_hit !== want.was_hit) begin
            fails++;
            $display("%0t: was_hit expected %0b got %0b", $realtime,
                     want.was_hit, out_was_hit);
          end
          if (out_wrote_back !== want.wrote_back) begin
            fails++;
            $display("%0t: wrote_back expected %0b got %0b", $realtime,
                     want.wrote_back, out_wrote_back);
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_words.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the cache testbench: clock, reset, request and pop traffic, verdict.
// Depends on dmwb_pkg, dmwb_tb_pkg, dmwb_checker and direct_mapped_writeback_cache_unit.
module tb;
  import dmwb_pkg::*;
  import dmwb_tb_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int POOL_SPAN    = 4 * NUM_LINES_DEF;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     push          = 1'b0;
  logic                     in_cmd        = 1'b0;
  logic [ADDR_PORT_W-1:0]   in_address    = '0;
  logic signed [WORD_W-1:0] in_write_data = '0;
  logic                     pop           = 1'b0;
  logic                     full;
  logic                     empty;
  logic signed [WORD_W-1:0] out_read_data;
  logic                     out_was_hit;
  logic                     out_wrote_back;
  int                       fail_count;
  int                       pending;
  bit                       steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  direct_mapped_writeback_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .in_address(in_address), .in_write_data(in_write_data), .empty(empty), .pop(pop),
    .out_read_data(out_read_data), .out_was_hit(out_was_hit),
    .out_wrote_back(out_wrote_back)
  );

  dmwb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_cmd(in_cmd),
    .in_address(in_address), .in_write_data(in_write_data), .empty(empty), .pop(pop),
    .out_read_data(out_read_data), .out_was_hit(out_was_hit),
    .out_wrote_back(out_wrote_back), .fail_count(fail_count), .pending(pending)
  );

  task automatic send_word(cache_cmd_e cmd, logic [ADDR_PORT_W-1:0] address,
                           logic [WORD_W-1:0] data);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd        <= cmd;
    in_address    <= address;
    in_write_data <= data;
    push          <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [ADDR_PORT_W-1:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1:    return ADDR_PORT_W'($urandom);
      2:       return ADDR_PORT_W'('1) - ADDR_PORT_W'($urandom_range(0, POOL_SPAN - 1));
      default: return ADDR_PORT_W'($urandom_range(0, POOL_SPAN - 1));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_READ,  16'd0,     32'd5);
    send_word(CMD_READ,  16'd0,     32'd0);
    send_word(CMD_WRITE, 16'd0,     32'h7fff_ffff);
    send_word(CMD_READ,  16'd4,     32'd0);
    send_word(CMD_WRITE, 16'd8,     32'h8000_0000);
    send_word(CMD_WRITE, 16'd8,     32'd0);
    send_word(CMD_READ,  16'd12,    32'hffff_ffff);
    send_word(CMD_READ,  16'hffff,  32'd0);
    send_word(CMD_WRITE, 16'hffff,  32'hffff_ffff);
    send_word(CMD_READ,  16'hffff,  32'd0);
    send_word(CMD_WRITE, 16'd3,     32'h1234_5678);
    send_word(CMD_WRITE, 16'd1,     32'h5555_5555);
    send_word(CMD_READ,  16'd1,     32'd0);
    send_word(CMD_WRITE, 16'd2,     32'haaaa_aaaa);
    send_word(CMD_READ,  16'hfffe,  32'd0);
    send_word(CMD_WRITE, 16'hfffd,  32'h0000_0001);
    send_word(CMD_READ,  16'd0,     32'd0);
    send_word(CMD_READ,  16'h8000,  32'd0);
    send_word(CMD_WRITE, 16'h7fff,  32'hdead_beef);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i % 150) >= 100 && (i % 150) < 130;
      if (i == 250) begin
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_word(cache_cmd_e'($urandom_range(0, 1)), pick_address(), pick_data());
    end
    push <= 1'b0;
    steady = 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/dmwb_pkg.sv
rtl/dmwb_front.sv
rtl/dmwb_queue.sv
rtl/dmwb_back.sv
rtl/direct_mapped_writeback_cache_unit.sv
sim/dmwb_checker.sv
sim/tb.sv
